[sv/rirr_pkg.sv]
// ----------------------------------------------------------------------------
// rirr_pkg
// Shared constants, types and helpers for the random-insertion recency
// replacement block.
// ----------------------------------------------------------------------------
package rirr_pkg;

    localparam int unsigned SETS     = 1024;
    localparam int unsigned WAYS     = 16;
    localparam int unsigned ADDR_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned WCNT_W   = $clog2(WAYS);
    localparam int unsigned POS_W    = 4;
    localparam int unsigned NIBBLES  = 16;
    localparam int unsigned DRAW_LIM = (WAYS < 4) ? WAYS : 4;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef logic [NIBBLES-1:0][POS_W-1:0] row_t;
    typedef logic [ADDR_W-1:0]             addr_t;

    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        addr_t addr;
        row_t  wr_data;
    } mem_req_t;

    // Row after reset: way w sits at position w, unused nibbles are zero.
    function automatic row_t reset_row();
        row_t r;
        r = '0;
        for (int w = 0; w < int'(WAYS); w++) begin
            r[w] = POS_W'(w);
        end
        return r;
    endfunction

    // Insertion position: draw reduced modulo min(WAYS, 4).
    function automatic logic [POS_W-1:0] draw_pos(input logic [1:0] d);
        logic [1:0] p;
        if (DRAW_LIM == 4) begin
            p = d;
        end else if (DRAW_LIM == 3) begin
            p = (d == 2'd3) ? 2'd0 : d;
        end else begin
            p = {1'b0, d[0]};
        end
        return {2'b00, p};
    endfunction

endpackage

[sv/rirr_row_mem.sv]
// ----------------------------------------------------------------------------
// rirr_row_mem
// Single-port store of one recency row per set, registered read data.
// ----------------------------------------------------------------------------
module rirr_row_mem
    import rirr_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output row_t     rd_data
);

    row_t mem [SETS];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.addr];
        end
    end

endmodule

[sv/random_insertion_recency_replacement_top.sv]
// ----------------------------------------------------------------------------
// random_insertion_recency_replacement_top
// Recency-position replacement state for a set-associative cache, with
// random insertion on fills and random promotion on hits to old ways.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per cache event. s_tuser is the kind
//   (0 = victim query, 1 = state update); s_tdata carries set, way, hit flag
//   and random draw. Result channel m_*: exactly one item per input item;
//   m_tdata holds the victim way (zero for updates), m_tuser is high when
//   the item answers a victim query.
//   Each item reads the set's row from the row store, then one compare and
//   increment unit walks the ways one per cycle, then an update writes the
//   row back (not for a hit on a young way or an invalid set or way). A new
//   item is taken only after the last one's result is in the output register.
//   After reset, a clearing pass writes the initial row into every set,
//   one set per cycle, with s_tready low.
//   A finished result waits in the output register while the next item is
//   taken and worked on; only if it still waits when the next result is
//   ready does the block hold that result and stay busy.
// ----------------------------------------------------------------------------
module random_insertion_recency_replacement_top
    import rirr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // set_index[9:0], way_index[13:10], was_hit[14],
                                   // random_draw[16:15], zero[23:17]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // victim_way[3:0], zero[7:4]
    output logic        m_tuser    // is_query_answer
);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(WAYS - 1);
    localparam logic [POS_W:0]   HALF    = (POS_W + 1)'(WAYS / 2);

    // Control registers
    logic [2:0]        state_reg,    state_next;
    addr_t             clr_reg,      clr_next;
    logic [WCNT_W-1:0] scan_reg,     scan_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Item and working registers
    logic              kind_reg,     kind_next;
    addr_t             set_reg,      set_next;
    logic              set_ok_reg,   set_ok_next;
    logic [3:0]        way_reg,      way_next;
    logic              hit_reg,      hit_next;
    logic [POS_W-1:0]  tp_reg,       tp_next;
    logic [POS_W-1:0]  hpos_reg,     hpos_next;
    row_t              row_reg,      row_next;
    logic [3:0]        best_reg,     best_next;
    logic [POS_W-1:0]  bestpos_reg,  bestpos_next;
    logic [3:0]        m_way_reg,    m_way_next;
    logic              m_query_reg,  m_query_next;

    mem_req_t          mem_req;
    row_t              mem_rd_data;
    row_t              row_fin;
    logic [3:0]        scan_idx;
    logic [POS_W-1:0]  scan_pos;
    logic              bump;
    logic              way_ok;
    logic              do_write;

    rirr_row_mem u_row_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_way_reg};
    assign m_tuser  = m_query_reg;

    // Shared unit: one way's position per cycle
    assign scan_idx = 4'(scan_reg);
    assign scan_pos = row_reg[scan_idx];
    assign bump     = (scan_pos >= tp_reg) && (scan_pos < POS_MAX)
                      && (!hit_reg || (scan_pos < hpos_reg));

    assign way_ok   = ({1'b0, way_reg} < (POS_W + 1)'(WAYS));
    assign do_write = set_ok_reg && way_ok && (!hit_reg || ({1'b0, hpos_reg} >= HALF));

    always_comb begin
        row_fin          = row_reg;
        row_fin[way_reg] = tp_reg;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        scan_next     = scan_reg;
        kind_next     = kind_reg;
        set_next      = set_reg;
        set_ok_next   = set_ok_reg;
        way_next      = way_reg;
        hit_next      = hit_reg;
        tp_next       = tp_reg;
        hpos_next     = hpos_reg;
        row_next      = row_reg;
        best_next     = best_reg;
        bestpos_next  = bestpos_reg;
        m_way_next    = m_way_reg;
        m_query_next  = m_query_reg;
        // drop the held result once taken
        m_tvalid_next = m_tvalid_reg && !m_tready;

        mem_req         = '0;
        mem_req.addr    = set_reg;
        mem_req.wr_data = row_fin;

        case (state_reg)
            ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.addr    = clr_reg;
                mem_req.wr_data = reset_row();
                clr_next        = clr_reg + addr_t'(1);
                if (clr_reg == addr_t'(SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = s_tuser;
                    set_next    = addr_t'(s_tdata[9:0]);
                    set_ok_next = (32'(s_tdata[9:0]) < SETS);
                    way_next    = s_tdata[13:10];
                    hit_next    = s_tdata[14];
                    tp_next     = draw_pos(s_tdata[16:15]);
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                mem_req.rd_en = set_ok_reg;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                row_next     = mem_rd_data;
                hpos_next    = mem_rd_data[way_reg];
                scan_next    = '0;
                best_next    = '0;
                bestpos_next = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                if (kind_reg == KIND_QUERY) begin
                    if ((scan_reg == '0) || (scan_pos > bestpos_reg)) begin
                        best_next    = scan_idx;
                        bestpos_next = scan_pos;
                    end
                end else if (bump) begin
                    row_next[scan_idx] = scan_pos + POS_W'(1);
                end
                if (scan_reg == WCNT_W'(WAYS - 1)) begin
                    state_next = ST_WRITE;
                end else begin
                    scan_next = scan_reg + WCNT_W'(1);
                end
            end
            ST_WRITE: begin
                // commit the moved row with the filled or hit way at its new slot
                mem_req.wr_en = (kind_reg == KIND_UPDATE) && do_write;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                // hold here until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_query_next  = (kind_reg == KIND_QUERY);
                    m_way_next    = ((kind_reg == KIND_QUERY) && set_ok_reg) ? best_reg : 4'd0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            scan_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            scan_reg     <= scan_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        set_reg     <= set_next;
        set_ok_reg  <= set_ok_next;
        way_reg     <= way_next;
        hit_reg     <= hit_next;
        tp_reg      <= tp_next;
        hpos_reg    <= hpos_next;
        row_reg     <= row_next;
        best_reg    <= best_next;
        bestpos_reg <= bestpos_next;
        m_way_reg   <= m_way_next;
        m_query_reg <= m_query_next;
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the random-insertion recency replacement block.
// Opening probes check the reset rows, the saturation and promotion
// boundaries and the fixed answer of updates. Random cache traffic follows,
// concentrated on a few sets. Each result is compared with an in-bench model
// of the per-set recency positions.
// ----------------------------------------------------------------------------
module tb;
    import rirr_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 12;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_LEN    = 400;     // long result-side hold-off
    localparam int HOLD_AT     = 800;     // random item that triggers it
    localparam int QUIET_FROM  = 300;     // random items with no idling
    localparam int QUIET_TO    = 450;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // set_index[9:0], way_index[13:10], was_hit[14],
                            // random_draw[16:15], zero[23:17]
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // victim_way[3:0], zero[7:4]
    logic        m_tuser;   // is_query_answer

    random_insertion_recency_replacement_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // One expected answer per accepted item.
    typedef struct packed {
        logic [3:0] victim;
        logic       is_query;
    } answer_t;

    // One row of the opening probes. When has_victim is set, the answer is
    // the typed one; otherwise it comes from the recency model.
    typedef struct packed {
        logic       kind;
        logic [9:0] set_idx;
        logic [3:0] way;
        logic       hit;
        logic [1:0] draw;
        logic       has_victim;
        logic [3:0] victim;
    } probe_row_t;

    localparam int NUM_PROBES = 22;

    probe_row_t opening_probes [NUM_PROBES] = '{
        // untouched sets: way 15 holds the largest position
        '{KIND_QUERY,  10'd0,    4'd0,  1'b0, 2'd0, 1'b1, 4'd15},
        '{KIND_QUERY,  10'd1023, 4'd0,  1'b0, 2'd0, 1'b1, 4'd15},
        '{KIND_QUERY,  10'd512,  4'd0,  1'b0, 2'd0, 1'b1, 4'd15},
        // fill at position 0: everything shifts, way 15 saturates
        '{KIND_UPDATE, 10'd0,    4'd0,  1'b0, 2'd0, 1'b1, 4'd0},
        '{KIND_QUERY,  10'd0,    4'd0,  1'b0, 2'd0, 1'b0, 4'd0},
        '{KIND_UPDATE, 10'd0,    4'd15, 1'b0, 2'd3, 1'b1, 4'd0},
        '{KIND_QUERY,  10'd0,    4'd0,  1'b0, 2'd0, 1'b0, 4'd0},
        // hit on an old way: promote
        '{KIND_UPDATE, 10'd0,    4'd14, 1'b1, 2'd1, 1'b1, 4'd0},
        '{KIND_QUERY,  10'd0,    4'd0,  1'b0, 2'd0, 1'b0, 4'd0},
        // hit on a young way: no change; then more hits, fills and queries elsewhere
        '{KIND_UPDATE, 10'd0,    4'd2,  1'b1, 2'd2, 1'b1, 4'd0},
        '{KIND_QUERY,  10'd0,    4'd0,  1'b0, 2'd0, 1'b0, 4'd0},
        '{KIND_UPDATE, 10'd1023, 4'd15, 1'b1, 2'd2, 1'b1, 4'd0},
        '{KIND_QUERY,  10'd1023, 4'd0,  1'b0, 2'd0, 1'b0, 4'd0},
        '{KIND_UPDATE, 10'd1023, 4'd15, 1'b0, 2'd3, 1'b1, 4'd0},
        '{KIND_QUERY,  10'd1023, 4'd0,  1'b0, 2'd0, 1'b0, 4'd0},
        '{KIND_UPDATE, 10'd682,  4'd10, 1'b0, 2'd2, 1'b1, 4'd0},
        '{KIND_QUERY,  10'd341,  4'd0,  1'b0, 2'd0, 1'b1, 4'd15},
        '{KIND_QUERY,  10'd682,  4'd0,  1'b0, 2'd0, 1'b0, 4'd0},
        // promotion: hits on way 8, then way 7, each at position WAYS/2 + 1
        '{KIND_UPDATE, 10'd682,  4'd8,  1'b1, 2'd0, 1'b1, 4'd0},
        '{KIND_QUERY,  10'd682,  4'd0,  1'b0, 2'd0, 1'b0, 4'd0},
        '{KIND_UPDATE, 10'd682,  4'd7,  1'b1, 2'd0, 1'b1, 4'd0},
        '{KIND_QUERY,  10'd682,  4'd0,  1'b0, 2'd0, 1'b0, 4'd0}
    };

    // Sets that most random traffic goes to, so rows get worked hard.
    int busy_sets [8] = '{0, 1, 2, 3, 511, 512, 1022, 1023};

    logic [POS_W-1:0] recency_pos [SETS][WAYS];
    answer_t          answers_due [$];
    int               mismatch_count = 0;
    int               cycle_count = 0;
    bit               quiet;          // no idling on either side
    bit               hold_request;   // ask the result side for a long hold

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    always begin
        aclk = 1'b1;
        #CLK_HALF;
        aclk = 1'b0;
        #CLK_HALF;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Recency model
    // ------------------------------------------------------------------
    function automatic void clear_recency();
        for (int s = 0; s < int'(SETS); s++) begin
            for (int w = 0; w < int'(WAYS); w++) begin
                recency_pos[s][w] = POS_W'(w);
            end
        end
    endfunction

    // Apply one cache event to the model; returns the victim way for a
    // query and zero for an update.
    function automatic logic [3:0] apply_access(input logic kind,
                                                input logic [9:0] set_idx,
                                                input logic [3:0] way,
                                                input logic hit,
                                                input logic [1:0] draw);
        logic [3:0] victim;
        int         top;
        int         ins;
        int         h;
        int         p;
        victim = 4'd0;
        if (kind == KIND_QUERY) begin
            if (int'(set_idx) < int'(SETS)) begin
                top = int'(recency_pos[set_idx][0]);
                for (int w = 1; w < int'(WAYS); w++) begin
                    if (int'(recency_pos[set_idx][w]) > top) begin
                        top    = int'(recency_pos[set_idx][w]);
                        victim = 4'(w);
                    end
                end
            end
            return victim;
        end
        // drop updates to sets or ways that do not exist
        if (int'(set_idx) >= int'(SETS) || int'(way) >= int'(WAYS)) begin
            return victim;
        end
        ins = int'(draw) % int'(DRAW_LIM);
        if (!hit) begin
            for (int w = 0; w < int'(WAYS); w++) begin
                p = int'(recency_pos[set_idx][w]);
                if (p >= ins && p < int'(WAYS) - 1) begin
                    recency_pos[set_idx][w] = POS_W'(p + 1);
                end
            end
            recency_pos[set_idx][way] = POS_W'(ins);
        end else begin
            h = int'(recency_pos[set_idx][way]);
            if (h >= int'(WAYS) / 2) begin
                for (int w = 0; w < int'(WAYS); w++) begin
                    p = int'(recency_pos[set_idx][w]);
                    if (p >= ins && p < h && p < int'(WAYS) - 1) begin
                        recency_pos[set_idx][w] = POS_W'(p + 1);
                    end
                end
                recency_pos[set_idx][way] = POS_W'(ins);
            end
        end
        return victim;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one item and hold it until the block takes it, then log the
    // answer it owes.
    task automatic offer_item(input logic kind, input logic [9:0] set_idx,
                              input logic [3:0] way, input logic hit,
                              input logic [1:0] draw, input logic has_victim,
                              input logic [3:0] typed_victim);
        answer_t    due;
        logic [3:0] modeled;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, draw, hit, way, set_idx};
        do @(posedge aclk); while (!s_tready);
        modeled      = apply_access(kind, set_idx, way, hit, draw);
        due.victim   = has_victim ? typed_victim : modeled;
        due.is_query = (kind == KIND_QUERY);
        answers_due.push_back(due);
    endtask

    // Idle the input for a random stretch: mostly none, some short, few long.
    task automatic idle_sender();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) gap = 0;
        else if (r < 95)     gap = $urandom_range(1, 3);
        else                 gap = $urandom_range(10, 50);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin : stimulus
        logic       kind;
        logic [9:0] set_idx;
        int         r;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = KIND_QUERY;
        quiet          = 1'b0;
        hold_request   = 1'b0;
        clear_recency();
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;

        // opening probes back to back, the block's clearing pass stalls them
        foreach (opening_probes[i]) begin
            offer_item(opening_probes[i].kind, opening_probes[i].set_idx,
                       opening_probes[i].way, opening_probes[i].hit,
                       opening_probes[i].draw, opening_probes[i].has_victim,
                       opening_probes[i].victim);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= QUIET_FROM && i < QUIET_TO);
            if (i == HOLD_AT) hold_request = 1'b1;
            kind = ($urandom_range(0, 1) == 0) ? KIND_QUERY : KIND_UPDATE;
            r    = $urandom_range(0, 99);
            if (r < 80) set_idx = 10'(busy_sets[$urandom_range(0, 7)]);
            else        set_idx = 10'($urandom_range(0, 1023));
            offer_item(kind, set_idx, 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       1'b0, 4'd0);
            idle_sender();
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        // drain, then watch a while for stray results
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: check, then choose the next ready
    // ------------------------------------------------------------------
    initial begin : results
        answer_t due;
        int      stall_left;
        int      hold_left;
        bit      hold_done;
        int      r;
        m_tready   = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result with nothing outstanding, got victim %0d query %0b",
                             $time, m_tdata[3:0], m_tuser);
                    mismatch_count++;
                end else begin
                    due = answers_due.pop_front();
                    if (m_tdata[3:0] != due.victim) begin
                        $display("%0t: victim_way expected %0d got %0d",
                                 $time, due.victim, m_tdata[3:0]);
                        mismatch_count++;
                    end
                    if (m_tuser != due.is_query) begin
                        $display("%0t: is_query_answer expected %0b got %0b",
                                 $time, due.is_query, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            // the long hold lets results back up so the input stalls
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (quiet || r >= 25) stall_left = 0;
                else if (r < 22)      stall_left = $urandom_range(1, 3);
                else                  stall_left = $urandom_range(10, 60);
                m_tready <= (stall_left == 0);
            end
        end
    end

endmodule
